>>> sv/tld_pkg.sv
package tld_pkg;

  localparam int GRID_X_DEF  = 8;
  localparam int GRID_Y_DEF  = 8;
  localparam int GRID_Z_DEF  = 8;
  localparam int STORE_DEPTH = 512;
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 10;
  localparam int PADDR_W     = 5;
  localparam int NUM_CORNERS = 8;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_INV_CELL_X,
    REG_INV_CELL_Y,
    REG_INV_CELL_Z,
    REG_POINT_COUNT
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } corner_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        inv_cell_x;
    logic [31:0]        inv_cell_y;
    logic [31:0]        inv_cell_z;
    logic [CNT_W-1:0]   cage_point_count;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [SA_W-1:0] cage_index;
    corner_t         pos;
    logic            empty;
  } side_t;

endpackage

>>> sv/tld_if.sv
interface tld_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [8:0]         cage_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, kind, cage_index, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, kind, cage_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface tld_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> sv/tld_cfg.sv
module tld_cfg
  import tld_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x         <= '0;
      cfg.origin_y         <= '0;
      cfg.origin_z         <= '0;
      cfg.inv_cell_x       <= 32'(ONE_Q16);
      cfg.inv_cell_y       <= 32'(ONE_Q16);
      cfg.inv_cell_z       <= 32'(ONE_Q16);
      cfg.cage_point_count <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ORIGIN_X:    cfg.origin_x <= pwdata;
        REG_ORIGIN_Y:    cfg.origin_y <= pwdata;
        REG_ORIGIN_Z:    cfg.origin_z <= pwdata;
        REG_INV_CELL_X:  cfg.inv_cell_x <= pwdata;
        REG_INV_CELL_Y:  cfg.inv_cell_y <= pwdata;
        REG_INV_CELL_Z:  cfg.inv_cell_z <= pwdata;
        REG_POINT_COUNT: cfg.cage_point_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:    prdata = cfg.origin_x;
      REG_ORIGIN_Y:    prdata = cfg.origin_y;
      REG_ORIGIN_Z:    prdata = cfg.origin_z;
      REG_INV_CELL_X:  prdata = cfg.inv_cell_x;
      REG_INV_CELL_Y:  prdata = cfg.inv_cell_y;
      REG_INV_CELL_Z:  prdata = cfg.inv_cell_z;
      REG_POINT_COUNT: prdata = 32'(cfg.cage_point_count);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> sv/tld_locate.sv
module tld_locate
  import tld_pkg::*;
#(
  parameter int GRID = GRID_X_DEF,
  localparam int CW  = $clog2(GRID)
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] pos,
  input  logic signed [31:0] org,
  input  logic [31:0]        inv,
  output logic [CW-1:0]      cell_idx,
  output logic [16:0]        frac
);

  logic signed [32:0] d;
  logic signed [49:0] ph;
  logic signed [49:0] pl;
  logic signed [50:0] lcl;
  logic signed [34:0] c_raw;
  logic [CW-1:0]      c_cl;
  logic signed [51:0] f_raw;
  logic [16:0]        f_cl;

  always_comb begin
    lcl   = 51'(ph) + 51'(pl >>> 16);
    c_raw = lcl[50:16];
    if (c_raw > $signed(35'(GRID - 2))) begin
      c_cl = CW'(GRID - 2);
    end else if (c_raw < 0) begin
      c_cl = '0;
    end else begin
      c_cl = c_raw[CW-1:0];
    end
    f_raw = 52'(lcl) - $signed({1'b0, 35'(c_cl), 16'b0});
    if (f_raw < 0) begin
      f_cl = '0;
    end else if (f_raw > $signed(52'(ONE_Q16))) begin
      f_cl = ONE_Q16;
    end else begin
      f_cl = f_raw[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d        <= 33'(pos) - 33'(org);
      ph       <= d * $signed({1'b0, inv[31:16]});
      pl       <= d * $signed({1'b0, inv[15:0]});
      cell_idx <= c_cl;
      frac     <= f_cl;
    end
  end

endmodule

>>> sv/tld_store.sv
module tld_store
  import tld_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic            wr_en,
  input  logic [SA_W-1:0] wr_addr,
  input  corner_t         wr_data,
  input  logic [SA_W-1:0] rd_addr [NUM_CORNERS],
  output corner_t         rd_data [NUM_CORNERS]
);

  // one read replica per corner, all written together
  corner_t mem [NUM_CORNERS][STORE_DEPTH];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      if (wr_en) begin
        mem[c][wr_addr] <= wr_data;
      end
      if (en) begin
        rd_data[c] <= mem[c][rd_addr[c]];
      end
    end
  end

endmodule

>>> sv/tld_blend.sv
module tld_blend
  import tld_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF,
  localparam int CWX   = $clog2(GRID_X),
  localparam int CWY   = $clog2(GRID_Y),
  localparam int CWZ   = $clog2(GRID_Z)
) (
  input  logic               clk,
  input  logic               en,
  input  logic [CWX-1:0]     cx,
  input  logic [CWY-1:0]     cy,
  input  logic [CWZ-1:0]     cz,
  input  logic [16:0]        fx,
  input  logic [16:0]        fy,
  input  logic [16:0]        fz,
  input  corner_t            pos,
  input  logic [CNT_W-1:0]   count,
  output logic [SA_W-1:0]    rd_addr [NUM_CORNERS],
  input  corner_t            rd_data [NUM_CORNERS],
  output logic signed [52:0] sum_x,
  output logic signed [52:0] sum_y,
  output logic signed [52:0] sum_z
);

  localparam int NPTS = GRID_X * GRID_Y * GRID_Z;
  localparam int IW   = ($clog2(NPTS) > CNT_W) ? $clog2(NPTS) : CNT_W;

  logic [CNT_W-1:0]   cnt_eff;
  logic [IW-1:0]      idx [NUM_CORNERS];
  logic               cv_n [NUM_CORNERS];
  logic [16:0]        ws [2];
  logic [16:0]        wt [2];
  logic [16:0]        wu_n [2];

  logic [32:0]        ab [4];
  logic [16:0]        wu [2];
  logic               cv [NUM_CORNERS];
  corner_t            pos5;
  logic [49:0]        abc [NUM_CORNERS];

  logic [16:0]        w [NUM_CORNERS];
  corner_t            val [NUM_CORNERS];

  logic signed [49:0] px [NUM_CORNERS];
  logic signed [49:0] py [NUM_CORNERS];
  logic signed [49:0] pz [NUM_CORNERS];

  logic signed [50:0] qx [4];
  logic signed [50:0] qy [4];
  logic signed [50:0] qz [4];

  always_comb begin
    cnt_eff = (count > CNT_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : count;
    ws[0]   = ONE_Q16 - fx;
    ws[1]   = fx;
    wt[0]   = ONE_Q16 - fy;
    wt[1]   = fy;
    wu_n[0] = ONE_Q16 - fz;
    wu_n[1] = fz;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      idx[c] = (IW'(cx) + IW'(c % 2))
             + (IW'(cy) + IW'((c / 2) % 2)) * IW'(GRID_X)
             + (IW'(cz) + IW'(c / 4)) * IW'(GRID_X * GRID_Y);
      cv_n[c]    = idx[c] < IW'(cnt_eff);
      rd_addr[c] = idx[c][SA_W-1:0];
    end
    for (int c = 0; c < NUM_CORNERS; c++) begin
      abc[c] = 50'(ab[c % 4]) * 50'(wu[c / 4]) + 50'(64'h8000_0000);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        ab[c] <= 33'(ws[c % 2]) * 33'(wt[c / 2]);
      end
      wu   <= wu_n;
      cv   <= cv_n;
      pos5 <= pos;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        w[c]   <= abc[c][48:32];
        val[c] <= cv[c] ? rd_data[c] : pos5;
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
        px[c] <= val[c].x * $signed({1'b0, w[c]});
        py[c] <= val[c].y * $signed({1'b0, w[c]});
        pz[c] <= val[c].z * $signed({1'b0, w[c]});
      end
      for (int c = 0; c < 4; c++) begin
        qx[c] <= 51'(px[2*c]) + 51'(px[2*c+1]);
        qy[c] <= 51'(py[2*c]) + 51'(py[2*c+1]);
        qz[c] <= 51'(pz[2*c]) + 51'(pz[2*c+1]);
      end
      sum_x <= 53'(qx[0]) + 53'(qx[1]) + 53'(qx[2]) + 53'(qx[3]);
      sum_y <= 53'(qy[0]) + 53'(qy[1]) + 53'(qy[2]) + 53'(qy[3]);
      sum_z <= 53'(qz[0]) + 53'(qz[1]) + 53'(qz[2]) + 53'(qz[3]);
    end
  end

endmodule

>>> sv/trilinear_lattice_deform.sv
// Trilinear lattice deformation in Q16.16 fixed point.
// Items enter on the item channel (valid/ready). A load item (kind 0)
// writes one lattice point into the cage store and gives no result; a
// vertex item (kind 1) gives one deformed position on the result channel.
// Registers (origin, reciprocal cell size, cage point count) sit on the
// APB port; write them only while no item is in flight.
// One item is taken every cycle while the skid register is empty.
// A vertex result goes through the chain of position subtract,
// reciprocal multiply, cell clamp, weight products, cage store read,
// corner multiply and a two level adder tree. The cage store holds one
// read replica per corner so all eight corners are read in the same cycle.
// Store writes and reads happen in one pipeline stage, in item order.
// The store is undefined after reset until points are loaded; reset
// clears the registers and empties the pipeline.
// When the receiver stalls, the output register holds its result and one
// more result lands in a skid register; item.ready then drops until the
// skid register drains.
module trilinear_lattice_deform
  import tld_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic               clk,
  input  logic               rst,
  tld_in_if.sink             item,
  tld_out_if.source          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NST = 9;
  localparam int CWX = $clog2(GRID_X);
  localparam int CWY = $clog2(GRID_Y);
  localparam int CWZ = $clog2(GRID_Z);

  cfg_t               cfg;
  logic               en;
  logic [NST:1]       v;
  side_t              sd [1:NST];
  logic [CWX-1:0]     cx;
  logic [CWY-1:0]     cy;
  logic [CWZ-1:0]     cz;
  logic [16:0]        fx;
  logic [16:0]        fy;
  logic [16:0]        fz;
  logic [SA_W-1:0]    rd_addr [NUM_CORNERS];
  corner_t            rd_data [NUM_CORNERS];
  logic signed [52:0] sum_x;
  logic signed [52:0] sum_y;
  logic signed [52:0] sum_z;
  logic               pv;
  corner_t            p;
  logic               o_valid;
  corner_t            o_data;
  logic               s_valid;
  corner_t            s_data;

  function automatic logic signed [31:0] rnd_sat(input logic signed [52:0] a);
    logic signed [53:0] r;
    logic signed [37:0] q;
    r = 54'(a) + 54'(32768);
    q = r[53:16];
    if (q > $signed(38'(32'h7fff_ffff))) begin
      rnd_sat = 32'h7fff_ffff;
    end else if (q < -$signed(38'(32'h8000_0000))) begin
      rnd_sat = 32'h8000_0000;
    end else begin
      rnd_sat = q[31:0];
    end
  endfunction

  tld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en         = !s_valid;
  assign item.ready = !s_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-1:1], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1].kind       <= item.kind;
      sd[1].cage_index <= item.cage_index;
      sd[1].pos        <= '{item.pos_x, item.pos_y, item.pos_z};
      sd[1].empty      <= cfg.cage_point_count == '0;
      for (int s = 2; s <= NST; s++) begin
        sd[s] <= sd[s-1];
      end
    end
  end

  tld_locate #(.GRID(GRID_X)) u_loc_x (
    .clk (clk), .en (en), .pos (sd[1].pos.x), .org (cfg.origin_x),
    .inv (cfg.inv_cell_x), .cell_idx (cx), .frac (fx)
  );

  tld_locate #(.GRID(GRID_Y)) u_loc_y (
    .clk (clk), .en (en), .pos (sd[1].pos.y), .org (cfg.origin_y),
    .inv (cfg.inv_cell_y), .cell_idx (cy), .frac (fy)
  );

  tld_locate #(.GRID(GRID_Z)) u_loc_z (
    .clk (clk), .en (en), .pos (sd[1].pos.z), .org (cfg.origin_z),
    .inv (cfg.inv_cell_z), .cell_idx (cz), .frac (fz)
  );

  tld_store u_store (
    .clk     (clk),
    .en      (en),
    .wr_en   (en && v[4] && !sd[4].kind),
    .wr_addr (sd[4].cage_index),
    .wr_data (sd[4].pos),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tld_blend #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_blend (
    .clk     (clk),
    .en      (en),
    .cx      (cx),
    .cy      (cy),
    .cz      (cz),
    .fx      (fx),
    .fy      (fy),
    .fz      (fz),
    .pos     (sd[4].pos),
    .count   (cfg.cage_point_count),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .sum_x   (sum_x),
    .sum_y   (sum_y),
    .sum_z   (sum_z)
  );

  // empty cage passes the position through
  always_comb begin
    pv = v[NST] && sd[NST].kind;
    if (sd[NST].empty) begin
      p = sd[NST].pos;
    end else begin
      p = '{rnd_sat(sum_x), rnd_sat(sum_y), rnd_sat(sum_z)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!s_valid) begin
      if (!o_valid || result.ready) begin
        o_valid <= pv;
        o_data  <= p;
      end else if (pv) begin
        s_valid <= 1'b1;
        s_data  <= p;
      end
    end else if (result.ready) begin
      o_data  <= s_data;
      s_valid <= 1'b0;
    end
  end

  assign result.valid = o_valid;
  assign result.out_x = o_data.x;
  assign result.out_y = o_data.y;
  assign result.out_z = o_data.z;

endmodule

>>> sv/tld_checker.sv
module tld_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_x,
  input logic        pready
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_x))
    else $error("stalled result changed");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> res_valid)
    else $error("input blocked with no result pending");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind trilinear_lattice_deform tld_checker u_tld_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_x     (result.out_x),
  .pready    (pready)
);

>>> sim/trilinear_lattice_deform_tb.sv
`timescale 1ns / 1ps

module trilinear_lattice_deform_tb;
  import tld_pkg::*;

  localparam int GX = GRID_X_DEF;
  localparam int GY = GRID_Y_DEF;
  localparam int GZ = GRID_Z_DEF;
  localparam int UNUSED_REG = 7;
  localparam int LONG_HOLD = 300;
  localparam bit KIND_LOAD = 1'b0;
  localparam bit KIND_VERTEX = 1'b1;

  typedef struct {
    logic            kind;
    logic [SA_W-1:0] cage_index;
    corner_t         pos;
  } lattice_item_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tld_in_if item ();
  tld_out_if result ();

  trilinear_lattice_deform dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lattice_item_t pending_items[$];
  corner_t expected_points[$];
  cfg_t cfg_mirror;
  corner_t cage_x_y_z[STORE_DEPTH];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int send_gap;
  int recv_stall;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // cell index and clamped fraction along one axis
  task automatic locate_axis(input logic signed [31:0] p, input logic signed [31:0] org,
                             input logic [31:0] inv, input int grid,
                             output longint cell_i, output longint frac);
    longint d, hi, lo, lv;
    d = longint'(p) - longint'(org);
    hi = inv[31:16];
    lo = inv[15:0];
    lv = d * hi + ((d * lo) >>> 16);
    cell_i = lv >>> 16;
    if (cell_i > grid - 2) cell_i = grid - 2;
    if (cell_i < 0) cell_i = 0;
    frac = lv - cell_i * 65536;
    if (frac < 0) frac = 0;
    if (frac > 65536) frac = 65536;
  endtask

  function automatic logic signed [31:0] round_sat(input longint acc);
    longint v;
    v = (acc + 32768) >>> 16;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic deform_predict(input lattice_item_t it);
    longint ci, cj, ck, s, t, u, w, idx, ax, ay, az;
    longint ws[2], wt[2], wu[2];
    corner_t v, r;
    if (it.kind == KIND_LOAD) begin
      cage_x_y_z[it.cage_index] = it.pos;
      return;
    end
    if (cfg_mirror.cage_point_count == 0) begin
      expected_points = {expected_points, it.pos};
      return;
    end
    locate_axis(it.pos.x, cfg_mirror.origin_x, cfg_mirror.inv_cell_x, GX, ci, s);
    locate_axis(it.pos.y, cfg_mirror.origin_y, cfg_mirror.inv_cell_y, GY, cj, t);
    locate_axis(it.pos.z, cfg_mirror.origin_z, cfg_mirror.inv_cell_z, GZ, ck, u);
    ws[0] = 65536 - s; ws[1] = s;
    wt[0] = 65536 - t; wt[1] = t;
    wu[0] = 65536 - u; wu[1] = u;
    ax = 0; ay = 0; az = 0;
    for (int dk = 0; dk < 2; dk++)
      for (int dj = 0; dj < 2; dj++)
        for (int di = 0; di < 2; di++) begin
          idx = (ci + di) + (cj + dj) * GX + (ck + dk) * GX * GY;
          w = (ws[di] * wt[dj] * wu[dk] + 64'sd2147483648) >>> 32;
          v = it.pos;
          if (idx < longint'(cfg_mirror.cage_point_count) && idx < STORE_DEPTH)
            v = cage_x_y_z[idx];
          ax += longint'(v.x) * w;
          ay += longint'(v.y) * w;
          az += longint'(v.z) * w;
        end
    r.x = round_sat(ax);
    r.y = round_sat(ay);
    r.z = round_sat(az);
    expected_points = {expected_points, r};
  endtask

  initial begin
    item.valid = 1'b0;
    item.kind = 1'b0;
    item.cage_index = '0;
    item.pos_x = '0;
    item.pos_y = '0;
    item.pos_z = '0;
    result.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
  end

  // item driver
  always @(posedge clk) begin
    lattice_item_t it;
    if (rst) begin
      item.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (item.valid && item.ready) begin
        it.kind = item.kind;
        it.cage_index = item.cage_index;
        it.pos.x = item.pos_x;
        it.pos.y = item.pos_y;
        it.pos.z = item.pos_z;
        deform_predict(it);
      end
      if (!item.valid || item.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          item.valid <= 1'b1;
          item.kind <= it.kind;
          item.cage_index <= it.cage_index;
          item.pos_x <= it.pos.x;
          item.pos_y <= it.pos.y;
          item.pos_z <= it.pos.z;
          if (idle_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    corner_t e;
    if (rst) begin
      result.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result %h %h %h", result.out_x, result.out_y, result.out_z);
        end else begin
          e = expected_points.pop_front();
          if (e.x !== result.out_x || e.y !== result.out_y || e.z !== result.out_z) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h %h %h, got %h %h %h",
                       e.x, e.y, e.z, result.out_x, result.out_y, result.out_z);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        result.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        recv_stall <= LONG_HOLD;
        result.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        recv_stall <= $urandom_range(0, 15);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input int addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr[PADDR_W-1:0];
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    apb_write(4 * int'(r), v);
    case (r)
      REG_ORIGIN_X: cfg_mirror.origin_x = v;
      REG_ORIGIN_Y: cfg_mirror.origin_y = v;
      REG_ORIGIN_Z: cfg_mirror.origin_z = v;
      REG_INV_CELL_X: cfg_mirror.inv_cell_x = v;
      REG_INV_CELL_Y: cfg_mirror.inv_cell_y = v;
      REG_INV_CELL_Z: cfg_mirror.inv_cell_z = v;
      REG_POINT_COUNT: cfg_mirror.cage_point_count = v[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || item.valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic push_item(input logic k, input logic [SA_W-1:0] idx,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    lattice_item_t it;
    it.kind = k;
    it.cage_index = idx;
    it.pos.x = x;
    it.pos.y = y;
    it.pos.z = z;
    pending_items = {pending_items, it};
  endtask

  // coordinate roughly inside the lattice, from -1 to 9 cells off the origin
  function automatic logic [31:0] near_lattice(input logic [31:0] org, input logic [31:0] inv);
    longint g, d;
    g = longint'($urandom_range(0, 10 * 65536)) - 65536;
    d = (g <<< 32) / longint'({32'd0, inv});
    return org + d[31:0];
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(0, 6))
      0: return 32'd1;
      1: return 32'hffff_ffff;
      2: return 32'h0001_0000;
      3: return 32'h0000_8000;
      4: return 32'h0000_4000;
      5: return 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 6))
      0: return 32'd1;
      1: return 32'd511;
      2: return 32'd512;
      3: return 32'd1023;
      4: return 32'd64;
      default: return $urandom_range(1, 1023);
    endcase
  endfunction

  task automatic random_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85)
        push_item(KIND_VERTEX, SA_W'($urandom()),
                  near_lattice(cfg_mirror.origin_x, cfg_mirror.inv_cell_x),
                  near_lattice(cfg_mirror.origin_y, cfg_mirror.inv_cell_y),
                  near_lattice(cfg_mirror.origin_z, cfg_mirror.inv_cell_z));
      else if (r < 92)
        push_item(KIND_VERTEX, SA_W'($urandom()), $urandom(), $urandom(), $urandom());
      else
        push_item(KIND_LOAD, SA_W'($urandom()), $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [31:0] v;
    cfg_mirror.origin_x = '0;
    cfg_mirror.origin_y = '0;
    cfg_mirror.origin_z = '0;
    cfg_mirror.inv_cell_x = 32'h0001_0000;
    cfg_mirror.inv_cell_y = 32'h0001_0000;
    cfg_mirror.inv_cell_z = 32'h0001_0000;
    cfg_mirror.cage_point_count = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty cage passes the position through
    push_item(KIND_VERTEX, 9'h1ff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    push_item(KIND_VERTEX, 9'h0, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
    push_item(KIND_VERTEX, 9'h155, 32'h0001_8000, 32'h0, 32'hffff_ffff);
    drain();

    // fill the whole cage store; the lowest cell holds extreme points
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if ((i & ~(1 | GX | GX * GY)) == 0)
        push_item(KIND_LOAD, SA_W'(i), 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      else
        push_item(KIND_LOAD, SA_W'(i), ((i % GX) << 16) + $urandom_range(0, 32'h3fff),
                  $urandom(), ((i / (GX * GY)) << 16) ^ 32'h8000);
    end
    drain();

    cfg_write(REG_POINT_COUNT, 32'd512);
    apb_write(4 * UNUSED_REG, 32'hdead_beef);
    push_item(KIND_VERTEX, 9'h0, 32'h0, 32'h0, 32'h0);
    push_item(KIND_VERTEX, 9'h1ff, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    push_item(KIND_VERTEX, 9'h0, 32'h0000_0001, 32'h0000_ffff, 32'h0000_4000);
    push_item(KIND_VERTEX, 9'h0, 32'h0007_0000, 32'h0007_0000, 32'h0007_0000);
    push_item(KIND_VERTEX, 9'h0, 32'hfffd_0000, 32'h0064_0000, 32'h0003_4000);
    push_item(KIND_VERTEX, 9'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0006_8000);
    push_item(KIND_VERTEX, 9'h0, 32'h0003_4000, 32'h0001_c000, 32'h0006_8000);
    drain();
    cfg_write(REG_POINT_COUNT, 32'd9);
    push_item(KIND_VERTEX, 9'h0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    push_item(KIND_VERTEX, 9'h0, 32'h0000_c000, 32'h0000_4000, 32'h0000_2000);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      v = pick_origin();
      cfg_write(REG_ORIGIN_X, v);
      v = pick_origin();
      cfg_write(REG_ORIGIN_Y, v);
      v = pick_origin();
      cfg_write(REG_ORIGIN_Z, v);
      v = pick_inv();
      cfg_write(REG_INV_CELL_X, v);
      v = pick_inv();
      cfg_write(REG_INV_CELL_Y, v);
      v = pick_inv();
      cfg_write(REG_INV_CELL_Z, v);
      v = (ph == 0) ? 32'd0 : pick_count();
      cfg_write(REG_POINT_COUNT, v);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 8) idle_on = 1'b0;
      random_items(ph == 8 ? 120 : 95);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_points.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
